### design/nqse_pkg.sv
package nqse_pkg;

    // result and register port geometry
    localparam int PLACE_W     = 48;
    localparam int NIBBLE_ROWS = 12;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int BSIZE_W     = 4;

    localparam logic [BSIZE_W-1:0] BOARD_SIZE_RESET = 4'd8;

    // word index of board_size (paddr[2])
    localparam logic REG_BOARD_SIZE = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PREP   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_EMIT   = 4'b1000
    } nqse_state_t;

    typedef struct packed {
        logic clear;   // drop search state
        logic prep;    // set up the walk for this request
        logic step;    // one placement / backtrack step
        logic emit;    // load the result word
    } nqse_cmd_t;

    typedef struct packed {
        logic search_done;
        logic finish;      // current step ends the walk
    } nqse_status_t;

endpackage

### design/nqse_ctrl.sv
module nqse_ctrl
    import nqse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         restart,
    input  nqse_status_t status,
    output nqse_cmd_t    cmd,
    output logic         busy
);

    nqse_state_t state_reg;
    nqse_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.clear  = restart;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                if (status.search_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.finish)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### design/nqse_datapath.sv
module nqse_datapath
    import nqse_pkg::*;
#(
    parameter int MAX_SIZE = 12
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  nqse_cmd_t                         cmd,
    input  logic                              cfg_clear,
    input  logic [$clog2(MAX_SIZE+1)-1:0]     size,
    output nqse_status_t                      status,
    output logic [PLACE_W-1:0]                placement,
    output logic                              found,
    output logic                              exhausted,
    output logic                              done
);

    localparam int CW  = $clog2(MAX_SIZE + 1);
    localparam int RW  = $clog2(MAX_SIZE);
    localparam int DW  = 2 * MAX_SIZE - 1;
    localparam int DIW = $clog2(DW);

    logic [RW-1:0]       row_arr [MAX_SIZE];

    logic [CW-1:0]       col_reg, col_next;
    logic [CW-1:0]       r_reg, r_next;
    logic [MAX_SIZE-1:0] rows_reg, rows_next;
    logic [DW-1:0]       fall_reg, fall_next;
    logic [DW-1:0]       rise_reg, rise_next;
    logic                sdone_reg, sdone_next;

    logic [PLACE_W-1:0]  placement_reg;
    logic                found_reg;
    logic                exhausted_reg;
    logic                done_reg;

    logic                r_lt_n;
    logic [RW-1:0]       r_idx;
    logic [DIW-1:0]      fi, ri;
    logic                free;
    logic                put;
    logic [CW-1:0]       bt_col;
    logic [RW-1:0]       bt_row;
    logic [DIW-1:0]      bt_fi, bt_ri;
    logic [PLACE_W-1:0]  place_build;

    // square test at (col_reg, r_reg)
    assign r_lt_n = (r_reg < size);
    assign r_idx  = r_reg[RW-1:0];
    assign fi     = DIW'(r_idx) + DIW'(MAX_SIZE - 1) - DIW'(col_reg[RW-1:0]);
    assign ri     = DIW'(r_idx) + DIW'(col_reg[RW-1:0]);
    assign free   = !rows_reg[r_idx] && !fall_reg[fi] && !rise_reg[ri];
    assign put    = cmd.step && r_lt_n && free;

    // backtrack target: last column on resume, else the previous column
    assign bt_col = cmd.prep ? (size - CW'(1)) : (col_reg - CW'(1));
    assign bt_row = row_arr[bt_col[RW-1:0]];
    assign bt_fi  = DIW'(bt_row) + DIW'(MAX_SIZE - 1) - DIW'(bt_col[RW-1:0]);
    assign bt_ri  = DIW'(bt_row) + DIW'(bt_col[RW-1:0]);

    assign status.search_done = sdone_reg;
    assign status.finish      = r_lt_n ? (free && (col_reg + CW'(1) == size))
                                       : (col_reg == '0);

    always_comb
    begin
        col_next   = col_reg;
        r_next     = r_reg;
        rows_next  = rows_reg;
        fall_next  = fall_reg;
        rise_next  = rise_reg;
        sdone_next = sdone_reg;
        if (cfg_clear || cmd.clear)
        begin
            col_next   = '0;
            rows_next  = '0;
            fall_next  = '0;
            rise_next  = '0;
            sdone_next = 1'b0;
        end
        else if (cmd.prep)
        begin
            if (!sdone_reg)
            begin
                if (col_reg >= size)
                begin
                    col_next          = bt_col;
                    r_next            = CW'(bt_row) + CW'(1);
                    rows_next[bt_row] = 1'b0;
                    fall_next[bt_fi]  = 1'b0;
                    rise_next[bt_ri]  = 1'b0;
                end
                else
                begin
                    r_next = '0;
                end
            end
        end
        else if (cmd.step)
        begin
            if (r_lt_n)
            begin
                if (free)
                begin
                    rows_next[r_idx] = 1'b1;
                    fall_next[fi]    = 1'b1;
                    rise_next[ri]    = 1'b1;
                    col_next         = col_reg + CW'(1);
                    r_next           = '0;
                end
                else
                begin
                    r_next = r_reg + CW'(1);
                end
            end
            else if (col_reg == '0)
            begin
                sdone_next = 1'b1;
            end
            else
            begin
                col_next          = bt_col;
                r_next            = CW'(bt_row) + CW'(1);
                rows_next[bt_row] = 1'b0;
                fall_next[bt_fi]  = 1'b0;
                rise_next[bt_ri]  = 1'b0;
            end
        end
    end

    // row index of each column -> column nibble of each row
    always_comb
    begin
        place_build = '0;
        for (int c = 0; c < MAX_SIZE; c++)
        begin
            for (int rr = 0; rr < NIBBLE_ROWS; rr++)
            begin
                if ((CW'(c) < size) && (int'(row_arr[c]) == rr))
                begin
                    place_build[rr*4 +: 4] = place_build[rr*4 +: 4] | 4'(c);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            r_reg     <= '0;
            rows_reg  <= '0;
            fall_reg  <= '0;
            rise_reg  <= '0;
            sdone_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            r_reg     <= r_next;
            rows_reg  <= rows_next;
            fall_reg  <= fall_next;
            rise_reg  <= rise_next;
            sdone_reg <= sdone_next;
            done_reg  <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            row_arr[col_reg[RW-1:0]] <= r_idx;
        end
        if (cmd.emit)
        begin
            placement_reg <= sdone_reg ? '0 : place_build;
            found_reg     <= !sdone_reg;
            exhausted_reg <= sdone_reg;
        end
    end

    assign placement = placement_reg;
    assign found     = found_reg;
    assign exhausted = exhausted_reg;
    assign done      = done_reg;

endmodule

### design/n_queens_solution_enumerator.sv
// N-queens enumerator: depth-first backtracking, one placement or backtrack step per cycle.
// The time from start to the done strobe depends on S, the search steps to the next
// solution (data dependent, zero once exhausted); busy stays high until done.
// A new request is taken only once the last one is done; the next start is taken in the done cycle.
// Reset (rst_n, async low): board_size 8, search cleared; results are never stalled.
module n_queens_solution_enumerator
    import nqse_pkg::*;
#(
    parameter int MAX_SIZE = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  restart,
    output logic [PLACE_W-1:0]    placement,
    output logic                  found,
    output logic                  exhausted,
    output logic                  done,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_SIZE + 1);

    logic [BSIZE_W-1:0] bsize_reg;
    logic               cfg_wr;
    logic [CW-1:0]      size;
    nqse_cmd_t          cmd;
    nqse_status_t       status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BOARD_SIZE);
    assign prdata = (paddr[2] == REG_BOARD_SIZE)
                  ? APB_DATA_W'(bsize_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg <= BOARD_SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            bsize_reg <= pwdata[BSIZE_W-1:0];
        end
    end

    // size 0 runs as 1, oversize saturates
    always_comb
    begin
        if (bsize_reg == '0)
        begin
            size = CW'(1);
        end
        else if ({1'b0, bsize_reg} > 5'(MAX_SIZE))
        begin
            size = CW'(MAX_SIZE);
        end
        else
        begin
            size = CW'(bsize_reg);
        end
    end

    nqse_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .restart (restart),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    nqse_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_clear (cfg_wr),
        .size      (size),
        .status    (status),
        .placement (placement),
        .found     (found),
        .exhausted (exhausted),
        .done      (done)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import nqse_pkg::*;

    localparam int  QMAX       = 12;
    localparam int  DIAG_W     = 2 * QMAX - 1;
    localparam int  N_RANDOM   = 500;
    // word index past the register map: writes there must be ignored
    localparam logic REG_UNUSED = 1'b1;

    typedef struct packed {
        logic [PLACE_W-1:0] plc;
        logic               fnd;
    } solution_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic                  restart = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic                  busy;
    logic [PLACE_W-1:0]    placement;
    logic                  found;
    logic                  exhausted;
    logic                  done;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    n_queens_solution_enumerator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .restart   (restart),
        .placement (placement),
        .found     (found),
        .exhausted (exhausted),
        .done      (done),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [BSIZE_W-1:0] board_reg;
    logic [3:0]         queen_row [QMAX];
    int                 col_count;
    logic [QMAX-1:0]    row_mask;
    logic [DIAG_W-1:0]  fall_mask;
    logic [DIAG_W-1:0]  rise_mask;
    bit                 is_done;

    solution_t pending_solutions [$];
    solution_t want;
    int        mismatches = 0;
    int        burst_left = 0;

    function automatic int board_n();
        int n;
        n = board_reg;
        if (n == 0)
            n = 1;
        if (n > QMAX)
            n = QMAX;
        return n;
    endfunction

    function automatic void clear_board();
        for (int i = 0; i < QMAX; i++)
            queen_row[i] = '0;
        col_count = 0;
        row_mask  = '0;
        fall_mask = '0;
        rise_mask = '0;
        is_done   = 1'b0;
    endfunction

    function automatic bit square_open(int c, int r);
        return !row_mask[r] && !fall_mask[r + QMAX - 1 - c] && !rise_mask[r + c];
    endfunction

    function automatic void mark_queen(int c, int r, bit on);
        if (on)
            queen_row[c] = 4'(r);
        row_mask[r]                = on;
        fall_mask[r + QMAX - 1 - c] = on;
        rise_mask[r + c]           = on;
    endfunction

    // advance the depth-first walk to the next full placement
    function automatic void next_solution(input bit rs, output solution_t sol);
        int n;
        int c;
        int r;
        bit hit;
        n       = board_n();
        hit     = 1'b0;
        sol.plc = '0;
        if (rs)
            clear_board();
        if (!is_done)
        begin
            c = col_count;
            if (c >= n)
            begin
                // resume past the last solution
                c = n - 1;
                r = queen_row[c];
                mark_queen(c, r, 1'b0);
                r++;
            end
            else
                r = 0;
            forever
            begin
                if (r < n)
                begin
                    if (square_open(c, r))
                    begin
                        mark_queen(c, r, 1'b1);
                        c++;
                        if (c == n)
                        begin
                            hit = 1'b1;
                            break;
                        end
                        r = 0;
                    end
                    else
                        r++;
                end
                else
                begin
                    if (c == 0)
                    begin
                        is_done = 1'b1;
                        break;
                    end
                    c--;
                    r = queen_row[c];
                    mark_queen(c, r, 1'b0);
                    r++;
                end
            end
            col_count = c;
        end
        if (hit)
            for (c = 0; c < n; c++)
                sol.plc[4 * queen_row[c] +: 4] = 4'(c);
        sol.fnd = hit;
    endfunction

    // result checker: the block cannot be stalled, so every strobe is taken
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_solutions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: placement=%h found=%b exhausted=%b",
                             placement, found, exhausted);
            end
            else
            begin
                want = pending_solutions.pop_front();
                if (placement !== want.plc || found !== want.fnd || exhausted !== !want.fnd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp placement=%h found=%b exhausted=%b, got %h %b %b",
                                 want.plc, want.fnd, !want.fnd, placement, found, exhausted);
                end
            end
        end
    end

    task automatic send_word(input bit rs);
        solution_t sol;
        start   <= 1'b1;
        restart <= rs;
        do
            @(posedge clk);
        while (busy);
        next_solution(rs, sol);
        pending_solutions.push_back(sol);
    endtask

    task automatic pause(input int cycles);
        start   <= 1'b0;
        restart <= 1'($urandom_range(0, 1));
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_in_bursts(input bit rs);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 12));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_word(rs);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [BSIZE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~32'hF) | APB_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BOARD_SIZE)
        begin
            board_reg = val;
            clear_board();
        end
    endtask

    task automatic set_size(input logic [BSIZE_W-1:0] val);
        drain();
        write_reg(REG_BOARD_SIZE, val);
    endtask

    // reset state: eight queens, walk starts without a restart
    task automatic test_reset_default();
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b0);
        drain();
    endtask

    // small boards run dry; exhaustion must stick until a restart
    task automatic test_exhaust_small();
        set_size(4'd1);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        set_size(4'd2);
        send_word(1'b0);
        set_size(4'd3);
        send_word(1'b1);
        set_size(4'd4);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        drain();
    endtask

    // zero acts as one, sizes past the maximum saturate
    task automatic test_size_extremes();
        set_size(4'd0);
        send_word(1'b0);
        send_word(1'b0);
        set_size(4'd15);
        send_word(1'b0);
        send_word(1'b1);
        set_size(4'd12);
        send_word(1'b0);
        drain();
    endtask

    // a size write drops the walk, a write outside the map does not
    task automatic test_config_clears();
        set_size(4'd6);
        send_word(1'b0);
        send_word(1'b0);
        drain();
        write_reg(REG_UNUSED, 4'd3);
        send_word(1'b0);
        set_size(4'd6);
        send_word(1'b0);
        drain();
    endtask

    task automatic test_random_walk();
        int sent;
        int sel;
        int phase_len;
        logic [BSIZE_W-1:0] sz;
        sent = 0;
        while (sent < N_RANDOM)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 10)
                sz = 4'($urandom_range(1, 6));
            else if (sel < 15)
                sz = 4'($urandom_range(7, 8));
            else if (sel < 18)
                sz = 4'($urandom_range(9, 11));
            else if (sel == 18)
                sz = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(12, 15));
            else
                sz = board_reg;
            if (sel == 19)
            begin
                drain();
                write_reg(REG_UNUSED, 4'($urandom_range(0, 15)));
            end
            else
                set_size(sz);
            burst_left = 0;
            // big boards are slow per solution, keep their phases short
            phase_len = (board_n() >= 11) ? $urandom_range(3, 10) : $urandom_range(10, 40);
            for (int i = 0; i < phase_len; i++)
            begin
                send_in_bursts($urandom_range(0, 15) == 0);
                sent++;
            end
        end
        drain();
    endtask

    initial
    begin
        board_reg = BOARD_SIZE_RESET;
        clear_board();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_default();
        test_exhaust_small();
        test_size_extremes();
        test_config_clears();
        test_random_walk();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_solutions.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### n_queens_solution_enumerator.f
design/nqse_pkg.sv
design/nqse_ctrl.sv
design/nqse_datapath.sv
design/n_queens_solution_enumerator.sv
verif/tb.sv
